// ----- sv/dtr_pkg.sv -----
// Shared types, register indexes and helpers for the divider/timer block.
// No dependencies.
package dtr_pkg;

  localparam logic [7:0] TIMER_MAX = 8'hFF;

  // clock_select codes
  localparam logic [1:0] SEL_BIT10 = 2'd0;
  localparam logic [1:0] SEL_BIT4  = 2'd1;
  localparam logic [1:0] SEL_BIT6  = 2'd2;
  localparam logic [1:0] SEL_BIT8  = 2'd3;

  typedef enum logic [1:0] {
    REG_TIMER_ENABLE = 2'd0,
    REG_CLOCK_SELECT = 2'd1,
    REG_RELOAD_VALUE = 2'd2
  } reg_index_t;

  typedef enum logic {
    ACT_TICK  = 1'b0,
    ACT_WRITE = 1'b1
  } action_t;

  // One input word.
  typedef struct packed {
    logic       action;
    logic [7:0] cycles;
    logic [7:0] write_value;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic [7:0] divider_value;
    logic [7:0] counter_value;
    logic       timer_irq;
    logic       reload_done;
  } out_word_t;

  // Counter bit watched for each clock select code.
  function automatic logic [15:0] watched_bit(input logic [1:0] sel);
    logic [15:0] m;
    case (sel)
      SEL_BIT10: m = 16'h0400;
      SEL_BIT4:  m = 16'h0010;
      SEL_BIT6:  m = 16'h0040;
      default:   m = 16'h0100;
    endcase
    return m;
  endfunction

endpackage

// ----- sv/dtr_in_reg.sv -----
// Input register stage: holds one accepted word until the core takes it.
// Depends on dtr_pkg.
module dtr_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dtr_pkg::in_word_t in_word,
  output logic              held_valid,
  output dtr_pkg::in_word_t held_word,
  input  logic              take
);
  import dtr_pkg::*;

  logic     valid_r;
  in_word_t word_r;
  logic     load;

  // Empty, or emptying this cycle: room for a new word.
  assign in_stall   = valid_r && !take;
  assign load       = in_valid && !in_stall;
  assign held_valid = valid_r;
  assign held_word  = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= in_word;
    end
  end

endmodule

// ----- sv/dtr_core.sv -----
// Timer state, configuration registers and the per-word update logic.
// Depends on dtr_pkg.
module dtr_core #(
  parameter int RELOAD_DELAY = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_wdata,
  input  logic               fire,
  input  dtr_pkg::in_word_t  word,
  output dtr_pkg::out_word_t result
);
  import dtr_pkg::*;

  localparam logic [7:0] DELAY = 8'(RELOAD_DELAY);

  logic        en_r;
  logic [1:0]  sel_r;
  logic [7:0]  reload_r;

  logic [15:0] sys_r,  sys_nxt;
  logic [7:0]  cnt_r,  cnt_nxt;
  logic        pend_r, pend_nxt;
  logic [7:0]  rem_r,  rem_nxt;

  logic        rld_fire;
  logic [7:0]  cnt_a;
  logic        edge_hit;
  logic        irq;

  always_comb begin
    sys_nxt  = sys_r;
    cnt_nxt  = cnt_r;
    pend_nxt = pend_r;
    rem_nxt  = rem_r;
    rld_fire = 1'b0;
    edge_hit = 1'b0;
    irq      = 1'b0;
    cnt_a    = cnt_r;
    if (word.action == ACT_WRITE) begin
      cnt_nxt = word.write_value;
    end else begin
      sys_nxt = sys_r + {8'd0, word.cycles};
      // countdown: fires once the remaining cycles are used up
      rld_fire = pend_r && (word.cycles >= rem_r);
      if (rld_fire) begin
        cnt_a    = reload_r;
        pend_nxt = 1'b0;
        rem_nxt  = 8'd0;
      end else if (pend_r) begin
        rem_nxt = rem_r - word.cycles;
      end
      // reload first, then the increment and overflow test act on the reloaded value
      edge_hit = en_r && |((sys_r ^ sys_nxt) & watched_bit(sel_r));
      cnt_nxt  = cnt_a;
      if (edge_hit) begin
        if (cnt_a == TIMER_MAX) begin
          cnt_nxt  = 8'd0;
          pend_nxt = 1'b1;
          rem_nxt  = DELAY;
          irq      = 1'b1;
        end else begin
          cnt_nxt = cnt_a + 8'd1;
        end
      end
    end
    result.divider_value = sys_nxt[15:8];
    result.counter_value = cnt_nxt;
    result.timer_irq     = irq;
    result.reload_done   = rld_fire;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sys_r  <= '0;
      cnt_r  <= '0;
      pend_r <= 1'b0;
      rem_r  <= '0;
    end else if (fire) begin
      sys_r  <= sys_nxt;
      cnt_r  <= cnt_nxt;
      pend_r <= pend_nxt;
      rem_r  <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r     <= 1'b0;
      sel_r    <= 2'd0;
      reload_r <= 8'd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_TIMER_ENABLE: en_r     <= cfg_wdata[0];
        REG_CLOCK_SELECT: sel_r    <= cfg_wdata[1:0];
        REG_RELOAD_VALUE: reload_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/dtr_out_reg.sv -----
// Result register: holds one result word until the consumer takes it.
// Depends on dtr_pkg.
module dtr_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  dtr_pkg::out_word_t word,
  output logic               can_load,
  output logic               out_valid,
  input  logic               out_stall,
  output dtr_pkg::out_word_t held_word
);
  import dtr_pkg::*;

  logic      valid_r;
  out_word_t word_r;

  assign can_load  = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign held_word = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= word;
    end
  end

endmodule

// ----- sv/divider_timer_with_reload.sv -----
// Divider and timer with delayed reload: top level.
// Path: an accepted word waits in the input register, then the core result is loaded
// into the result register; out_stall alone holds words back in either register.
// Throughput: one word per cycle while out_stall is low; the timer state updates in one pass per word.
// Reset (rst_n, synchronous, active low) clears counters, reload state,
// configuration registers and both stage valids.
// Depends on dtr_pkg, dtr_in_reg, dtr_core, dtr_out_reg.
module divider_timer_with_reload #(
  parameter int RELOAD_DELAY = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  // configuration write port
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_action,
  input  logic [7:0] in_cycles,
  input  logic [7:0] in_write_value,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_divider_value,
  output logic [7:0] out_counter_value,
  output logic       out_timer_irq,
  output logic       out_reload_done
);
  import dtr_pkg::*;

  in_word_t  in_word;
  in_word_t  held_word;
  logic      held_valid;
  out_word_t core_word;
  out_word_t res_word;
  logic      can_load;
  logic      fire;

  assign in_word.action      = in_action;
  assign in_word.cycles      = in_cycles;
  assign in_word.write_value = in_write_value;

  // A held word moves into the core when the result register has room;
  // the state update and the result load happen on the same edge.
  assign fire = held_valid && can_load;

  dtr_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .held_valid (held_valid),
    .held_word  (held_word),
    .take       (fire)
  );

  dtr_core #(
    .RELOAD_DELAY (RELOAD_DELAY)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .word      (held_word),
    .result    (core_word)
  );

  dtr_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .word      (core_word),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .held_word (res_word)
  );

  assign out_divider_value = res_word.divider_value;
  assign out_counter_value = res_word.counter_value;
  assign out_timer_irq     = res_word.timer_irq;
  assign out_reload_done   = res_word.reload_done;

endmodule
